@@ rtl/eesd_pkg.sv @@
`timescale 1ns / 1ps

package eesd_pkg;

    // Field and register widths
    localparam int BYTE_W      = 8;
    localparam int KEY_W       = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_SEED  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_MULT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_ADD   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEEP_WS   = 2'd3;

    // Register reset values (standard eexec key rule)
    localparam logic [KEY_W-1:0] KEY_SEED_RESET = 16'd55665;
    localparam logic [KEY_W-1:0] KEY_MULT_RESET = 16'd52845;
    localparam logic [KEY_W-1:0] KEY_ADD_RESET  = 16'd22719;

    // Input item
    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              section_start;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic [BYTE_W-1:0] plain_byte;
        logic              binary_mode;
    } out_item_t;

    // Key update constants seen by the back end
    typedef struct packed {
        logic [KEY_W-1:0] key_mult;
        logic [KEY_W-1:0] key_add;
    } key_rule_t;

    // One cipher byte handed from the front end to the back end
    typedef struct packed {
        logic [BYTE_W-1:0] cipher;
        logic              discard;   // lead byte: advance key, emit nothing
        logic              restart;   // load seed before this byte
        logic              binary;
        logic [KEY_W-1:0]  seed;
    } q_entry_t;

    // Space, tab, LF, VT, FF, CR
    function automatic logic is_ws(input logic [BYTE_W-1:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    function automatic logic is_hex(input logic [BYTE_W-1:0] b);
        return ((b >= 8'h30) && (b <= 8'h39)) ||
               ((b >= 8'h41) && (b <= 8'h46)) ||
               ((b >= 8'h61) && (b <= 8'h66));
    endfunction

    // Non-hex characters read as zero
    function automatic logic [3:0] hex_val(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] v;
        v = 8'h00;
        if ((b >= 8'h30) && (b <= 8'h39)) begin
            v = b - 8'h30;
        end
        else if ((b >= 8'h41) && (b <= 8'h46)) begin
            v = b - 8'h37;
        end
        else if ((b >= 8'h61) && (b <= 8'h66)) begin
            v = b - 8'h57;
        end
        return v[3:0];
    endfunction

endpackage

@@ rtl/eesd_queue.sv @@
`timescale 1ns / 1ps

module eesd_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  eesd_pkg::q_entry_t push_data,
    input  logic              pop,
    output logic              head_valid,
    output eesd_pkg::q_entry_t head_data,
    output logic              full
);
    import eesd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    q_entry_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == DEPTH_CNT);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots, no reset
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/eesd_front.sv @@
`timescale 1ns / 1ps

module eesd_front #(
    parameter int LEAD_BYTES = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  eesd_pkg::in_item_t             in_data,
    input  logic [eesd_pkg::KEY_W-1:0]     key_seed,
    input  logic                           keep_whitespace,
    input  logic                           q_full,
    output logic                           q_push,
    output eesd_pkg::q_entry_t             q_entry
);
    import eesd_pkg::*;

    localparam int DW = $clog2(LEAD_BYTES);
    localparam logic [DW-1:0] DISCARD_BIN = (LEAD_BYTES > 4) ? DW'(LEAD_BYTES - 4) : '0;
    localparam logic [DW-1:0] DISCARD_ASC = DW'(LEAD_BYTES - 2);

    typedef enum logic [1:0] {
        ST_DETECT,
        ST_FLUSH,
        ST_STREAM
    } state_t;

    state_t            state_reg, state_next, eff_state;
    logic [1:0]        count_reg, count_next, eff_count;
    logic [1:0]        flush_idx_reg, flush_idx_next;
    logic              binary_reg, binary_next;
    logic [3:0]        high_reg, high_next;
    logic              nib_valid_reg, nib_valid_next, eff_nib_valid;
    logic [DW-1:0]     discard_reg, discard_next;
    logic [KEY_W-1:0]  seed_reg, seed_next;
    logic [BYTE_W-1:0] detect_buf_reg [4];
    logic              buf_we;
    logic              accept, restart_now, flush_last, all_hex;
    logic [BYTE_W-1:0] b, flush_byte;

    assign in_stall    = (state_reg == ST_FLUSH) || q_full;
    assign accept      = in_valid && !in_stall;
    assign b           = in_data.in_byte;
    assign restart_now = accept && in_data.section_start;

    // A section mark restarts detection on this very byte
    assign eff_state     = restart_now ? ST_DETECT : state_reg;
    assign eff_count     = restart_now ? 2'd0 : count_reg;
    assign eff_nib_valid = restart_now ? 1'b0 : nib_valid_reg;

    assign all_hex = is_hex(detect_buf_reg[0]) && is_hex(detect_buf_reg[1]) &&
                     is_hex(detect_buf_reg[2]) && is_hex(b);

    // Lead bytes replayed from the detection buffer
    always_comb
    begin
        case (flush_idx_reg)
            2'd0:    flush_byte = binary_reg ? detect_buf_reg[0]
                                 : {hex_val(detect_buf_reg[0]), hex_val(detect_buf_reg[1])};
            2'd1:    flush_byte = binary_reg ? detect_buf_reg[1]
                                 : {hex_val(detect_buf_reg[2]), hex_val(detect_buf_reg[3])};
            2'd2:    flush_byte = detect_buf_reg[2];
            default: flush_byte = detect_buf_reg[3];
        endcase
    end

    assign flush_last = binary_reg ? (flush_idx_reg == 2'd3) : (flush_idx_reg == 2'd1);

    // Classification and next state
    always_comb
    begin
        state_next     = eff_state;
        count_next     = eff_count;
        flush_idx_next = flush_idx_reg;
        binary_next    = restart_now ? 1'b0 : binary_reg;
        high_next      = restart_now ? 4'h0 : high_reg;
        nib_valid_next = eff_nib_valid;
        discard_next   = restart_now ? '0 : discard_reg;
        seed_next      = restart_now ? key_seed : seed_reg;
        buf_we         = 1'b0;
        q_push         = 1'b0;
        q_entry.cipher  = b;
        q_entry.discard = 1'b0;
        q_entry.restart = 1'b0;
        q_entry.binary  = binary_reg;
        q_entry.seed    = seed_reg;

        unique case (eff_state)
            ST_DETECT:
            begin
                if (accept && !((eff_count == 2'd0) && !keep_whitespace && is_ws(b))) begin
                    buf_we = 1'b1;
                    if (eff_count == 2'd3) begin
                        binary_next    = !all_hex;
                        discard_next   = all_hex ? DISCARD_ASC : DISCARD_BIN;
                        flush_idx_next = 2'd0;
                        state_next     = ST_FLUSH;
                    end
                    else begin
                        count_next = eff_count + 2'd1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!q_full) begin
                    q_push          = 1'b1;
                    q_entry.cipher  = flush_byte;
                    q_entry.discard = 1'b1;
                    q_entry.restart = (flush_idx_reg == 2'd0);
                    if (flush_last) begin
                        state_next = ST_STREAM;
                    end
                    else begin
                        flush_idx_next = flush_idx_reg + 2'd1;
                    end
                end
            end
            ST_STREAM:
            begin
                if (accept) begin
                    if (binary_reg) begin
                        q_push = 1'b1;
                    end
                    else if (!is_ws(b)) begin
                        if (!eff_nib_valid) begin
                            high_next      = hex_val(b);
                            nib_valid_next = 1'b1;
                        end
                        else begin
                            nib_valid_next = 1'b0;
                            q_push         = 1'b1;
                            q_entry.cipher = {high_reg, hex_val(b)};
                        end
                    end
                    if (q_push && (discard_reg != '0)) begin
                        q_entry.discard = 1'b1;
                        discard_next    = discard_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_DETECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_DETECT;
            count_reg     <= 2'd0;
            flush_idx_reg <= 2'd0;
            binary_reg    <= 1'b0;
            high_reg      <= 4'h0;
            nib_valid_reg <= 1'b0;
            discard_reg   <= '0;
            seed_reg      <= KEY_SEED_RESET;
        end
        else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            flush_idx_reg <= flush_idx_next;
            binary_reg    <= binary_next;
            high_reg      <= high_next;
            nib_valid_reg <= nib_valid_next;
            discard_reg   <= discard_next;
            seed_reg      <= seed_next;
        end
    end

    // Detection buffer, no reset
    always_ff @(posedge clk)
    begin
        if (buf_we) begin
            detect_buf_reg[eff_count] <= b;
        end
    end

endmodule

@@ rtl/eesd_back.sv @@
`timescale 1ns / 1ps

module eesd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  eesd_pkg::q_entry_t q_head,
    output logic               q_pop,
    input  eesd_pkg::key_rule_t key_rule,
    output logic               out_valid,
    input  logic               out_stall,
    output eesd_pkg::out_item_t out_data
);
    import eesd_pkg::*;

    logic [KEY_W-1:0]   key_reg, key_next, key_cur, key_sum;
    logic [2*KEY_W-1:0] key_prod;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg;
    logic [BYTE_W-1:0]  plain;

    // Take the next byte whenever the output register is free or leaving
    assign q_pop = q_valid && (!out_valid_reg || !out_stall);

    // Key rule: plain = c ^ (r >> 8), r = (c + r) * mult + add
    assign key_cur  = q_head.restart ? q_head.seed : key_reg;
    assign plain    = q_head.cipher ^ key_cur[KEY_W-1:BYTE_W];
    assign key_sum  = {{(KEY_W-BYTE_W){1'b0}}, q_head.cipher} + key_cur;
    assign key_prod = key_sum * key_rule.key_mult;
    assign key_next = key_prod[KEY_W-1:0] + key_rule.key_add;

    assign out_valid_next = (out_valid_reg && out_stall) || (q_pop && !q_head.discard);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_reg       <= KEY_SEED_RESET;
            out_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg <= out_valid_next;
            if (q_pop) begin
                key_reg <= key_next;
            end
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (q_pop && !q_head.discard) begin
            out_data_reg.plain_byte  <= plain;
            out_data_reg.binary_mode <= q_head.binary;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/eexec_stream_decrypt_core.sv @@
`timescale 1ns / 1ps
// Channel | Direction | Payload     | Handshake
// in      | input     | in_item_t   | in_valid / in_stall
// out     | output    | out_item_t  | out_valid / out_stall
// cfg     | input     | cfg_data    | cfg_write (cfg_index selects register)
//
// Streaming bytes go at one per cycle while in_stall and out_stall stay low; the limit is the key loop in the back
// end, one 16x16 multiply plus add per cipher byte.
// When the fourth detection byte arrives, in_stall rises while the buffered lead
// bytes are replayed: four in binary mode, two decoded bytes in ASCII hex mode.
// Reset clears all control state at once; there is no clearing pass.
// A streamed byte passes through the queue and then the output register before its result shows.

module eexec_stream_decrypt_core #(
    parameter int LEAD_BYTES  = 4,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  eesd_pkg::in_item_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output eesd_pkg::out_item_t                out_data,
    input  logic                               cfg_write,
    input  logic [eesd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [eesd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import eesd_pkg::*;

    logic [KEY_W-1:0] key_seed_reg, key_mult_reg, key_add_reg;
    logic             keep_ws_reg;
    key_rule_t        key_rule;
    logic             q_push, q_pop, q_full, q_valid;
    q_entry_t         q_entry, q_head;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_seed_reg <= KEY_SEED_RESET;
            key_mult_reg <= KEY_MULT_RESET;
            key_add_reg  <= KEY_ADD_RESET;
            keep_ws_reg  <= 1'b0;
        end
        else if (cfg_write) begin
            unique case (cfg_index)
                CFG_KEY_SEED: key_seed_reg <= cfg_data[KEY_W-1:0];
                CFG_KEY_MULT: key_mult_reg <= cfg_data[KEY_W-1:0];
                CFG_KEY_ADD:  key_add_reg  <= cfg_data[KEY_W-1:0];
                CFG_KEEP_WS:  keep_ws_reg  <= cfg_data[0];
                default:      keep_ws_reg  <= keep_ws_reg;
            endcase
        end
    end

    assign key_rule.key_mult = key_mult_reg;
    assign key_rule.key_add  = key_add_reg;

    eesd_front #(
        .LEAD_BYTES(LEAD_BYTES)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .key_seed        (key_seed_reg),
        .keep_whitespace (keep_ws_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_entry         (q_entry)
    );

    eesd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_entry),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head),
        .full       (q_full)
    );

    eesd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .key_rule  (key_rule),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

@@ rtl/eesd_checker.sv @@
`timescale 1ns / 1ps

module eesd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input eesd_pkg::out_item_t out_data
);
    import eesd_pkg::*;

    // Input transfers not yet matched by a result transfer
    logic [31:0] balance_reg;
    logic        in_xfer, out_xfer;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            balance_reg <= '0;
        end
        else begin
            balance_reg <= balance_reg + {31'd0, in_xfer} - {31'd0, out_xfer};
        end
    end

    // A pending result always has at least one unmatched input byte behind it
    a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (balance_reg != 32'd0))
        else $error("result shown without an input transfer behind it");

    // Right after reset the block is empty and takes input
    a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> (!in_stall && !out_valid))
        else $error("block not empty and ready after reset");

    a_out_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_data_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(out_data))
        else $error("out_data changed while stalled");

endmodule

bind eexec_stream_decrypt_core eesd_checker u_eesd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
